>>> src/bfsa_pkg.sv
// Shared types and constants for the block free stack allocator.
// No dependencies; every other file imports this package.
package bfsa_pkg;

  localparam int MaxBlocks = 4096;
  localparam int IdW       = $clog2(MaxBlocks);
  localparam int CntW      = IdW + 1;
  localparam int BlockIdW  = 16;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StRange = 2'd2,
    StFree  = 2'd3
  } status_e;

  typedef struct packed {
    logic                cmd;
    logic [BlockIdW-1:0] block_id;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [IdW-1:0]  granted_id;
    logic [CntW-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
    logic refill;
  } ctrl_t;

endpackage

>>> src/bfsa_ctrl.sv
// Controller state machine: sequences capture, lookup and commit of one beat, and refill.
// Depends on bfsa_pkg.
module bfsa_ctrl
  import bfsa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  cfg_valid_i,
  output logic  busy,
  output logic  cfg_ready_o,
  output logic  rsp_valid_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    Idle,
    Lookup,
    Commit
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;

  always_comb begin
    busy           = (state_q != Idle);
    cfg_ready_o    = (state_q == Idle);
    ctrl_o.capture = (state_q == Idle) && start;
    ctrl_o.lookup  = (state_q == Lookup);
    ctrl_o.commit  = (state_q == Commit);
    ctrl_o.refill  = (state_q == Idle) && cfg_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= (state_q == Commit);
      case (state_q)
        Idle: begin
          if (start) begin
            state_q <= Lookup;
          end
        end
        Lookup: begin
          state_q <= Commit;
        end
        Commit: begin
          state_q <= Idle;
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == Lookup))
    else $error("accepted beat did not advance to lookup");

  a_strobe_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ($past(state_q) == Commit))
    else $error("result strobe without commit");

endmodule

>>> src/bfsa_dp.sv
// Datapath: free stack memory, allocation bitmap, depth and low-water counters.
// Depends on bfsa_pkg.
module bfsa_dp
  import bfsa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  input  req_t            req_i,
  input  logic [CntW-1:0] cfg_data_i,
  output rsp_t            rsp_o
);

  logic [IdW-1:0] stack_mem [MaxBlocks];
  logic           mark_mem  [MaxBlocks];

  logic [CntW-1:0] bc_q, bc_d;
  logic [CntW-1:0] depth_q, depth_d;
  logic [CntW-1:0] low_q, low_d;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;

  logic [IdW-1:0]  stk_rd_q;
  logic            mark_rd_q;
  logic            top_fresh_q;
  logic            mark_valid_q;
  logic            in_range_q;

  logic [CntW-1:0] depth_m1;
  logic [CntW-1:0] touched;
  logic [IdW-1:0]  top_val;
  logic            mark_val;
  logic [IdW-1:0]  req_idx;

  logic            stk_we;
  logic [IdW-1:0]  stk_waddr;
  logic [IdW-1:0]  stk_wdata;
  logic            mark_we;
  logic [IdW-1:0]  mark_waddr;
  logic            mark_wdata;

  assign depth_m1 = depth_q - CntW'(1);
  assign touched  = bc_q - low_q;
  assign req_idx  = req_q.block_id[IdW-1:0];
  assign top_val  = top_fresh_q ? IdW'(bc_q - depth_q) : stk_rd_q;
  assign mark_val = mark_valid_q & mark_rd_q;

  always_comb begin
    bc_d       = bc_q;
    depth_d    = depth_q;
    low_d      = low_q;
    rsp_d      = rsp_q;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[IdW-1:0];
    stk_wdata  = req_idx;
    mark_we    = 1'b0;
    mark_waddr = req_idx;
    mark_wdata = 1'b0;
    if (ctrl_i.refill) begin
      bc_d    = (cfg_data_i > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : cfg_data_i;
      depth_d = bc_d;
      low_d   = bc_d;
    end else if (ctrl_i.commit) begin
      rsp_d.granted_id = '0;
      rsp_d.status     = StOk;
      if (req_q.cmd == CmdAlloc) begin
        if (depth_q == '0) begin
          rsp_d.status = StEmpty;
        end else begin
          depth_d          = depth_m1;
          rsp_d.granted_id = top_val;
          mark_we          = 1'b1;
          mark_waddr       = top_val;
          mark_wdata       = 1'b1;
          if (depth_m1 < low_q) begin
            low_d = depth_m1;
          end
        end
      end else begin
        if (!in_range_q) begin
          rsp_d.status = StRange;
        end else if (!mark_val) begin
          rsp_d.status = StFree;
        end else begin
          mark_we = 1'b1;
          if (depth_q < CntW'(MaxBlocks)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + CntW'(1);
          end
        end
      end
      rsp_d.free_count = depth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q    <= CntW'(MaxBlocks);
      depth_q <= CntW'(MaxBlocks);
      low_q   <= CntW'(MaxBlocks);
    end else begin
      bc_q    <= bc_d;
      depth_q <= depth_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (ctrl_i.capture) begin
      req_q <= req_i;
    end
    if (ctrl_i.lookup) begin
      stk_rd_q     <= stack_mem[depth_m1[IdW-1:0]];
      mark_rd_q    <= mark_mem[req_idx];
      top_fresh_q  <= (depth_m1 < low_q);
      mark_valid_q <= (req_q.block_id < BlockIdW'(touched));
      in_range_q   <= (req_q.block_id < BlockIdW'(bc_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
  end

  assign rsp_o = rsp_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q <= depth_q) && (depth_q <= bc_q) && (bc_q <= CntW'(MaxBlocks)))
    else $error("stack depth counters out of order");

  a_refill_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.refill |=> (depth_q == bc_q) && (low_q == bc_q))
    else $error("refill did not reload depth and low-water mark");

  a_alloc_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && (req_q.cmd == CmdAlloc) && (depth_q != '0))
      |=> (depth_q == $past(depth_q) - CntW'(1)))
    else $error("allocate did not pop the stack");

endmodule

>>> src/block_free_stack_allocator.sv
// Top level of the block free stack allocator: controller plus datapath.
// Depends on bfsa_pkg, bfsa_ctrl and bfsa_dp.
//
// A beat is accepted when start is high and busy is low, the stack top and the
// bitmap entry are read from their memories in the next cycle, and the update is
// committed in the cycle after that; the result shows on rsp_o with rsp_valid_o
// high for the single following cycle, and busy falls in that same cycle, so a
// new beat can be accepted only once the previous result shows.
// The receiver cannot stall and must take each result when rsp_valid_o is high.
// A write to block_count is taken while the block is idle and refills the
// stack at once: entries never written since then read as their refill value,
// so there is no clearing pass after reset or after a write.
module block_free_stack_allocator
  import bfsa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  output logic            rsp_valid_o,
  output rsp_t            rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i
);

  ctrl_t ctrl;

  bfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cfg_valid_i (cfg_valid_i),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .ctrl_o      (ctrl)
  );

  bfsa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for block_free_stack_allocator: named directed tests,
// then random alloc/free traffic over several block counts, checked per beat.
// Depends on bfsa_pkg and the block_free_stack_allocator RTL.
module tb_top;
  import bfsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  req_t            req_i       = '0;
  logic            rsp_valid_o;
  rsp_t            rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data_i  = '0;

  logic [IdW-1:0] free_ids [MaxBlocks];
  bit             taken    [MaxBlocks];
  int unsigned    free_depth;
  int unsigned    blocks_in_use;
  int unsigned    held_ids[$];
  rsp_t           alloc_result_q[$];
  int unsigned    mismatches;
  bit             steady;

  block_free_stack_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void refill_stack(input int unsigned count);
    blocks_in_use = count;
    for (int i = 0; i < MaxBlocks; i++) begin
      taken[i] = 1'b0;
      if (i < count) free_ids[i] = IdW'(count - 1 - i);
    end
    free_depth = count;
    held_ids.delete();
  endfunction

  function automatic rsp_t predict_alloc_op(input req_t op);
    rsp_t        r;
    int unsigned id;
    r.status     = StOk;
    r.granted_id = '0;
    id           = op.block_id;
    if (op.cmd == CmdAlloc) begin
      if (free_depth == 0) begin
        r.status = StEmpty;
      end else begin
        free_depth--;
        r.granted_id = free_ids[free_depth];
        taken[r.granted_id] = 1'b1;
        held_ids.push_back(r.granted_id);
      end
    end else if (id >= blocks_in_use) begin
      r.status = StRange;
    end else if (!taken[id]) begin
      r.status = StFree;
    end else begin
      taken[id] = 1'b0;
      foreach (held_ids[k]) begin
        if (held_ids[k] == id) begin
          held_ids.delete(k);
          break;
        end
      end
      if (free_depth < MaxBlocks) begin
        free_ids[free_depth] = IdW'(id);
        free_depth++;
      end
    end
    r.free_count = CntW'(free_depth);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected st=%0d id=%0d cnt=%0d, got st=%0d id=%0d cnt=%0d",
               $realtime, what, want.status, want.granted_id, want.free_count,
               got.status, got.granted_id, got.free_count);
  endtask

  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (alloc_result_q.size() == 0) begin
        note_mismatch("unexpected result", '0, rsp_o);
      end else begin
        want = alloc_result_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.granted_id !== want.granted_id ||
            rsp_o.free_count !== want.free_count)
          note_mismatch("result mismatch", want, rsp_o);
      end
    end
  end

  task automatic send_op(input logic cmd, input logic [BlockIdW-1:0] id);
    req_t op;
    op.cmd      = cmd;
    op.block_id = id;
    start <= 1'b1;
    req_i <= op;
    do @(posedge clk_i); while (busy);
    alloc_result_q.push_back(predict_alloc_op(op));
  endtask

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return;
    n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (alloc_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_block_count(input logic [CntW-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    refill_stack((value > MaxBlocks) ? MaxBlocks : value);
  endtask

  task automatic test_reset_fill();
    send_op(CmdAlloc, 16'h0000);
    send_op(CmdAlloc, 16'h0000);
    send_op(CmdFree,  16'd1);
    send_op(CmdAlloc, 16'hFFFF);
    send_op(CmdFree,  16'd4095);
    send_op(CmdFree,  16'd4096);
    send_op(CmdFree,  16'hFFFF);
    send_op(CmdFree,  16'd0);
    send_op(CmdFree,  16'd0);
  endtask

  task automatic test_single_block();
    write_block_count(CntW'(1));
    send_op(CmdAlloc, 16'h5A5A);
    send_op(CmdAlloc, 16'h0000);
    send_op(CmdFree,  16'd1);
    send_op(CmdFree,  16'd0);
    send_op(CmdFree,  16'd0);
  endtask

  task automatic test_zero_blocks();
    write_block_count(CntW'(0));
    send_op(CmdAlloc, 16'h0000);
    send_op(CmdFree,  16'd0);
  endtask

  task automatic test_oversize_count();
    write_block_count({CntW{1'b1}});
    send_op(CmdAlloc, 16'h0000);
    send_op(CmdFree,  16'd4095);
    send_op(CmdFree,  16'd4096);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned n);
    int unsigned         r;
    logic                cmd;
    logic [BlockIdW-1:0] id;
    write_block_count(CntW'(count));
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 0) steady = ($urandom_range(0, 3) == 0);
      r   = $urandom_range(0, 99);
      id  = BlockIdW'($urandom());
      cmd = CmdFree;
      if (r < 45) begin
        cmd = CmdAlloc;
      end else if (r < 80 && held_ids.size() != 0) begin
        id = BlockIdW'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
      end else if (r < 90 && blocks_in_use != 0) begin
        id = BlockIdW'($urandom_range(0, blocks_in_use - 1));
      end
      send_op(cmd, id);
      idle_gap();
    end
    steady = 1'b0;
  endtask

  initial begin
    steady     = 1'b0;
    mismatches = 0;
    refill_stack(MaxBlocks);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_fill();
    test_single_block();
    test_zero_blocks();
    test_oversize_count();
    test_random_traffic(2,    150);
    test_random_traffic(8,    250);
    test_random_traffic(1,    60);
    test_random_traffic(17,   200);
    test_random_traffic(64,   250);
    test_random_traffic(4096, 200);
    test_random_traffic(3,    140);

    start <= 1'b0;
    for (int i = 0; i < 200 && alloc_result_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatches += alloc_result_q.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
src/bfsa_pkg.sv
src/bfsa_ctrl.sv
src/bfsa_dp.sv
src/block_free_stack_allocator.sv
tb/sv/tb_top.sv
